// ===== rtl/core/sblf_pkg.sv =====
// Shared types, constants and scale tables of the stack blur line filter.
package sblf_pkg;

  localparam int unsigned RADIUS_W = 6;
  localparam int unsigned PIXEL_W  = 8;
  localparam int unsigned WEIGHT_W = RADIUS_W + 1;
  localparam int unsigned TAP_W    = RADIUS_W + 2;
  localparam int unsigned TPROD_W  = WEIGHT_W + PIXEL_W;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned MUL_W    = 10;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned PROD_W   = SUM_W + MUL_W;
  localparam int unsigned TABLE_N  = 2 ** RADIUS_W;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd2;
  localparam logic [PIXEL_W-1:0]  PIXEL_MAX    = 8'd255;

  // Register word index, taken from paddr[2].
  localparam logic REG_RADIUS = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_WAIT,
    ST_SCALE,
    ST_EMIT
  } sblf_state_e;

  typedef struct packed {
    logic                clr;
    logic                acc_en;
    logic [WEIGHT_W-1:0] weight;
    logic                scale_en;
    logic [RADIUS_W-1:0] radius;
  } sblf_mac_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
  } sblf_emit_t;

  localparam logic [MUL_W-1:0] SCALE_MUL [TABLE_N] = '{
    10'd512, 10'd512, 10'd456, 10'd512, 10'd328, 10'd456, 10'd335, 10'd512,
    10'd405, 10'd328, 10'd271, 10'd456, 10'd388, 10'd335, 10'd292, 10'd512,
    10'd454, 10'd405, 10'd364, 10'd328, 10'd298, 10'd271, 10'd496, 10'd456,
    10'd420, 10'd388, 10'd360, 10'd335, 10'd312, 10'd292, 10'd273, 10'd512,
    10'd482, 10'd454, 10'd428, 10'd405, 10'd383, 10'd364, 10'd345, 10'd328,
    10'd312, 10'd298, 10'd284, 10'd271, 10'd259, 10'd496, 10'd475, 10'd456,
    10'd437, 10'd420, 10'd404, 10'd388, 10'd374, 10'd360, 10'd347, 10'd335,
    10'd323, 10'd312, 10'd302, 10'd292, 10'd282, 10'd273, 10'd265, 10'd512
  };

  localparam logic [SHIFT_W-1:0] SCALE_SHIFT [TABLE_N] = '{
    5'd9,  5'd11, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15,
    5'd15, 5'd15, 5'd15, 5'd16, 5'd16, 5'd16, 5'd16, 5'd17,
    5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd18, 5'd18,
    5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd19,
    5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19,
    5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd20, 5'd20, 5'd20,
    5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20,
    5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd21
  };

endpackage

// ===== rtl/core/sblf_ring.sv =====
// Pixel window memory: one write port, one read port with registered data.
module sblf_ring #(
  parameter int unsigned DEPTH = 127,
  parameter int unsigned AW    = 7
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [sblf_pkg::PIXEL_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [sblf_pkg::PIXEL_W-1:0] rdata_o
);

  logic [sblf_pkg::PIXEL_W-1:0] mem_q [DEPTH];
  logic [sblf_pkg::PIXEL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sblf_mac.sv =====
// Weighted tap accumulator with table scaling and saturation.
module sblf_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sblf_pkg::sblf_mac_ctl_t       ctl_i,
  input  logic [sblf_pkg::PIXEL_W-1:0]  rdata_i,
  output logic [sblf_pkg::PIXEL_W-1:0]  blurred_o
);

  logic                            en_q;
  logic [sblf_pkg::WEIGHT_W-1:0]   w_q;
  logic [sblf_pkg::SUM_W-1:0]      acc_q;
  logic [sblf_pkg::PROD_W-1:0]     prod_q;
  logic [sblf_pkg::TPROD_W-1:0]    tap_prod;
  logic [sblf_pkg::PROD_W-1:0]     shifted;

  // Weight is registered, so it follows the read request by one register stage, in step with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      en_q <= ctl_i.acc_en;
      if (ctl_i.clr) begin
        acc_q <= '0;
      end else if (en_q) begin
        acc_q <= acc_q + sblf_pkg::SUM_W'(tap_prod);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= ctl_i.weight;
    if (ctl_i.scale_en) begin
      prod_q <= sblf_pkg::PROD_W'(acc_q) *
                sblf_pkg::PROD_W'(sblf_pkg::SCALE_MUL[ctl_i.radius]);
    end
  end

  assign tap_prod = sblf_pkg::TPROD_W'(w_q) * sblf_pkg::TPROD_W'(rdata_i);
  assign shifted  = prod_q >> sblf_pkg::SCALE_SHIFT[ctl_i.radius];

  always_comb begin
    if (|shifted[sblf_pkg::PROD_W-1:sblf_pkg::PIXEL_W]) begin
      blurred_o = sblf_pkg::PIXEL_MAX;
    end else begin
      blurred_o = shifted[sblf_pkg::PIXEL_W-1:0];
    end
  end

endmodule

// ===== rtl/core/sblf_ctrl.sv =====
// Sequencer: line tracking, ring addressing, tap walk and result hand-off.
module sblf_ctrl #(
  parameter int unsigned MAX_RADIUS = 63,
  parameter int unsigned MAX_LINE   = 4096,
  parameter int unsigned RING       = 127,
  parameter int unsigned PW         = 7,
  parameter int unsigned LW         = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [sblf_pkg::RADIUS_W-1:0]  radius_i,
  input  logic                           in_valid_i,
  input  logic                           in_last_i,
  output logic                           in_ready_o,
  input  logic                           out_free_i,
  output logic                           ring_we_o,
  output logic [PW-1:0]                  ring_waddr_o,
  output logic                           ring_re_o,
  output logic [PW-1:0]                  ring_raddr_o,
  output sblf_pkg::sblf_mac_ctl_t        mac_ctl_o,
  output sblf_pkg::sblf_emit_t           emit_o
);

  localparam int unsigned TW  = sblf_pkg::TAP_W;
  localparam int unsigned RW  = sblf_pkg::RADIUS_W;
  localparam int unsigned PSW = ((LW > TW) ? LW : TW) + 2;
  localparam int unsigned AW  = (LW > PW) ? LW : PW;
  localparam logic [PW:0]   RING_EXT = (PW + 1)'(RING);
  localparam logic [PW-1:0] RING_TOP = PW'(RING - 1);
  localparam logic [LW-1:0] LINE_TOP = LW'(MAX_LINE - 1);

  sblf_pkg::sblf_state_e state_q, state_d;

  logic [PW-1:0] ptr_q, ptr_d;
  logic [PW-1:0] head_q, head_d;
  logic [LW-1:0] pos_q, pos_d;
  logic [LW-1:0] ec_q, ec_d;
  logic [LW-1:0] newest_q, newest_d;
  logic [LW-1:0] x_q, x_d;
  logic [RW-1:0] lr_q, lr_d;
  logic [TW-1:0] k_q, k_d;
  logic          flush_q, flush_d;

  logic [RW-1:0]  radius_lim;
  logic [RW-1:0]  r_now;
  logic           at_end;
  logic           can_emit;
  logic           accept;
  logic           last_out;
  logic [PSW-1:0] tap_pos;
  logic [LW-1:0]  tap_clamp;
  logic [AW-1:0]  diff;
  logic [PW-1:0]  slot_lag;
  logic [PW-1:0]  slot;
  logic [TW-1:0]  abs_k;
  logic           tap_done;

  always_comb begin
    if (32'(radius_i) > MAX_RADIUS) begin
      radius_lim = RW'(MAX_RADIUS);
    end else begin
      radius_lim = radius_i;
    end
  end

  // Radius is sampled at the first pixel of a line.
  assign r_now    = (pos_q == '0) ? radius_lim : lr_q;
  assign at_end   = in_last_i || (pos_q == LINE_TOP);
  assign can_emit = 32'(pos_q) >= 32'(r_now);
  assign accept   = in_valid_i && in_ready_o;
  assign last_out = flush_q && (x_q == newest_q);

  // Tap position clamped to the pixels of this line, then mapped to its slot.
  always_comb begin
    tap_pos = PSW'(x_q) + {{(PSW - TW){k_q[TW-1]}}, k_q};
    if (tap_pos[PSW-1]) begin
      tap_clamp = '0;
    end else if (tap_pos > PSW'(newest_q)) begin
      tap_clamp = newest_q;
    end else begin
      tap_clamp = tap_pos[LW-1:0];
    end
    diff = AW'(newest_q) - AW'(tap_clamp);
    slot_lag = diff[PW-1:0];
    if (head_q >= slot_lag) begin
      slot = head_q - slot_lag;
    end else begin
      slot = PW'({1'b0, head_q} + RING_EXT - {1'b0, slot_lag});
    end
  end

  assign abs_k    = k_q[TW-1] ? (~k_q + TW'(1)) : k_q;
  assign tap_done = (k_q == {2'b00, lr_q});

  assign in_ready_o   = (state_q == sblf_pkg::ST_IDLE);
  assign ring_we_o    = accept;
  assign ring_waddr_o = ptr_q;
  assign ring_raddr_o = slot;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    head_d    = head_q;
    pos_d     = pos_q;
    ec_d      = ec_q;
    newest_d  = newest_q;
    x_d       = x_q;
    lr_d      = lr_q;
    k_d       = k_q;
    flush_d   = flush_q;
    ring_re_o = 1'b0;
    mac_ctl_o.clr      = 1'b0;
    mac_ctl_o.acc_en   = 1'b0;
    mac_ctl_o.weight   = {1'b0, lr_q} + sblf_pkg::WEIGHT_W'(1) - abs_k[sblf_pkg::WEIGHT_W-1:0];
    mac_ctl_o.scale_en = 1'b0;
    mac_ctl_o.radius   = lr_q;
    emit_o.valid = 1'b0;
    emit_o.last  = last_out;

    unique case (state_q)
      sblf_pkg::ST_IDLE: begin
        if (accept) begin
          ptr_d    = (ptr_q == RING_TOP) ? '0 : ptr_q + PW'(1);
          head_d   = ptr_q;
          newest_d = pos_q;
          lr_d     = r_now;
          x_d      = ec_q;
          k_d      = TW'(0) - {2'b00, r_now};
          mac_ctl_o.clr = 1'b1;
          if (at_end) begin
            pos_d   = '0;
            ec_d    = '0;
            flush_d = 1'b1;
            state_d = sblf_pkg::ST_TAP;
          end else begin
            pos_d   = pos_q + LW'(1);
            flush_d = 1'b0;
            if (can_emit) begin
              ec_d    = ec_q + LW'(1);
              state_d = sblf_pkg::ST_TAP;
            end
          end
        end
      end
      sblf_pkg::ST_TAP: begin
        ring_re_o        = 1'b1;
        mac_ctl_o.acc_en = 1'b1;
        if (tap_done) begin
          state_d = sblf_pkg::ST_WAIT;
        end else begin
          k_d = k_q + TW'(1);
        end
      end
      sblf_pkg::ST_WAIT: begin
        state_d = sblf_pkg::ST_SCALE;
      end
      sblf_pkg::ST_SCALE: begin
        mac_ctl_o.scale_en = 1'b1;
        state_d = sblf_pkg::ST_EMIT;
      end
      sblf_pkg::ST_EMIT: begin
        if (out_free_i) begin
          emit_o.valid = 1'b1;
          if (flush_q && !last_out) begin
            // advance to the next pending output of the line
            x_d = x_q + LW'(1);
            k_d = TW'(0) - {2'b00, lr_q};
            mac_ctl_o.clr = 1'b1;
            state_d = sblf_pkg::ST_TAP;
          end else begin
            state_d = sblf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sblf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sblf_pkg::ST_IDLE;
      ptr_q    <= '0;
      head_q   <= '0;
      pos_q    <= '0;
      ec_q     <= '0;
      newest_q <= '0;
      x_q      <= '0;
      lr_q     <= sblf_pkg::RADIUS_RESET;
      k_q      <= '0;
      flush_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      head_q   <= head_d;
      pos_q    <= pos_d;
      ec_q     <= ec_d;
      newest_q <= newest_d;
      x_q      <= x_d;
      lr_q     <= lr_d;
      k_q      <= k_d;
      flush_q  <= flush_d;
    end
  end

endmodule

// ===== rtl/core/stack_blur_line_filter_top.sv =====
// Top level of the stack blur line filter: config register, output stage, assertions.
//
// Usage: pixels of one line (row or column) enter on the s_axis channel, the
// last pixel of the line flagged by s_axis_tlast. Blurred pixels leave on
// m_axis, the final one of each line flagged by m_axis_tlast. The radius is
// written over the APB port while the block is idle and takes effect at the
// first pixel of the next line; values above MAX_RADIUS are clipped.
// Sequence: every output walks the 2r+1 window taps through the single read
// port of the pixel memory, one tap per cycle, then passes a wait state for
// the memory read, the scale multiply and the hand-off, which waits while the
// output register holds an untaken result. A pixel that releases an output
// holds the input until that output is handed off, one that releases none
// leaves it ready; a line end flushes the r+1 (or fewer) pending outputs in turn.
// Reset clears the line position, the memory pointer and the output stage and
// sets the radius to 2; the pixel memory needs no clearing pass. A stalled
// receiver holds the output register; the block still takes the next pixel
// and stops only when a further result finds that register occupied.
module stack_blur_line_filter_top #(
  parameter int unsigned MAX_RADIUS = 63,
  parameter int unsigned MAX_LINE   = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tlast,   // line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] blurred
  output logic        m_axis_tlast    // last
);

  localparam int unsigned RING = 2 * MAX_RADIUS + 1;
  localparam int unsigned PW   = $clog2(RING);
  localparam int unsigned LW   = $clog2(MAX_LINE);

  logic [sblf_pkg::RADIUS_W-1:0] radius_q;
  logic                          cfg_wr;

  logic                          ring_we;
  logic [PW-1:0]                 ring_waddr;
  logic                          ring_re;
  logic [PW-1:0]                 ring_raddr;
  logic [sblf_pkg::PIXEL_W-1:0]  ring_rdata;
  sblf_pkg::sblf_mac_ctl_t       mac_ctl;
  sblf_pkg::sblf_emit_t          emit;
  logic [sblf_pkg::PIXEL_W-1:0]  blurred;

  logic                          out_valid_q;
  logic [sblf_pkg::PIXEL_W-1:0]  out_data_q;
  logic                          out_last_q;
  logic                          out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == sblf_pkg::REG_RADIUS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= sblf_pkg::RADIUS_RESET;
    end else if (cfg_wr) begin
      radius_q <= pwdata[sblf_pkg::RADIUS_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == sblf_pkg::REG_RADIUS) begin
      prdata = 32'(radius_q);
    end else begin
      prdata = '0;
    end
  end

  sblf_ring #(
    .DEPTH (RING),
    .AW    (PW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  sblf_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .rdata_i   (ring_rdata),
    .blurred_o (blurred)
  );

  sblf_ctrl #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_LINE   (MAX_LINE),
    .RING       (RING),
    .PW         (PW),
    .LW         (LW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radius_i     (radius_q),
    .in_valid_i   (s_axis_tvalid),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .out_free_i   (out_free),
    .ring_we_o    (ring_we),
    .ring_waddr_o (ring_waddr),
    .ring_re_o    (ring_re),
    .ring_raddr_o (ring_raddr),
    .mac_ctl_o    (mac_ctl),
    .emit_o       (emit)
  );

  // Output stage: load when empty or when the held request is taken.
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_data_q <= blurred;
      out_last_q <= emit.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> (!out_valid_q || m_axis_tready))
    else $error("result loaded over an untaken output request");

  a_line_end_flushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("line end did not start a flush");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit.valid && emit.last) |=> s_axis_tready)
    else $error("controller not idle after final output of a line");
`endif

endmodule
